[src/wkpc_pkg.sv]
`default_nettype none

package wkpc_pkg;

  // Default number of digits a PIN may hold.
  localparam int PIN_CAPACITY_DEF = 16;
  // Widest digit count over the supported capacity range (up to 127 digits).
  localparam int CMD_CNT_W = 7;

  localparam int CODE_W    = 64;
  localparam int BITS_W    = 7;
  localparam int DIGIT_W   = 4;
  localparam int TIMEOUT_W = 20;

  localparam logic [TIMEOUT_W-1:0] IDLE_TIMEOUT_RST = TIMEOUT_W'(10000);

  localparam logic [BITS_W-1:0] KEY4_BITS  = BITS_W'(4);
  localparam logic [BITS_W-1:0] KEY8_BITS  = BITS_W'(8);
  localparam logic [BITS_W-1:0] CARD26_BITS = BITS_W'(26);
  localparam logic [BITS_W-1:0] CARD34_BITS = BITS_W'(34);
  localparam logic [DIGIT_W-1:0] FIRST_TERM_KEY = DIGIT_W'(10);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CARD   = 2'd1,
    OP_DRAIN  = 2'd2
  } cmd_op_t;

  // Command from the front end to the back end. For an append, cnt holds the
  // store index; for a drain, it holds the number of stored digits.
  typedef struct packed {
    cmd_op_t                op;
    logic [CODE_W-1:0]      code;
    logic [BITS_W-1:0]      bits;
    logic [DIGIT_W-1:0]     digit;
    logic [CMD_CNT_W-1:0]   cnt;
  } cmd_t;

endpackage

`default_nettype wire

[src/wkpc_if.sv]
`default_nettype none

interface wkpc_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] frame_code;
  logic [6:0]  frame_bits;
  logic        locked;

  modport source (output valid, output action, output frame_code, output frame_bits,
                  output locked, input ready);
  modport sink   (input valid, input action, input frame_code, input frame_bits,
                  input locked, output ready);
endinterface

interface wkpc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] card_code;
  logic [3:0]  pin_digit;
  logic [6:0]  source_bits;
  logic        last;

  modport source (output valid, output kind, output card_code, output pin_digit,
                  output source_bits, output last, input ready);
  modport sink   (input valid, input kind, input card_code, input pin_digit,
                  input source_bits, input last, output ready);
endinterface

`default_nettype wire

[src/wkpc_front.sv]
`default_nettype none

module wkpc_front #(
  parameter int PinCapacity = wkpc_pkg::PIN_CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [wkpc_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  wkpc_in_if.sink                             in_ch,
  input  wire logic                           q_full,
  output      logic                           q_push,
  output      wkpc_pkg::cmd_t                 q_data
);
  import wkpc_pkg::*;

  localparam int CNT_W = $clog2(PinCapacity + 1);

  logic [TIMEOUT_W-1:0] idle_timeout_ticks;
  logic [CNT_W-1:0]     digit_count, digit_count_next;
  logic [TIMEOUT_W-1:0] idle_ticks, idle_ticks_next;

  logic             in_acc;
  logic [CNT_W-1:0] cnt_eff;
  logic             is_key;
  logic             key_ok;
  logic [DIGIT_W-1:0] key;
  logic [CODE_W-1:0]  card;
  logic             want_push;

  assign in_ch.ready = !q_full;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    key    = in_ch.frame_code[3:0];
    is_key = (in_ch.frame_bits == KEY4_BITS) || (in_ch.frame_bits == KEY8_BITS);
    key_ok = (in_ch.frame_bits == KEY4_BITS) || (in_ch.frame_code[7:4] == ~key);

    card = in_ch.frame_code;
    if (in_ch.frame_bits == CARD26_BITS) begin
      card = {40'd0, in_ch.frame_code[24:1]};
    end else if (in_ch.frame_bits == CARD34_BITS) begin
      card = {32'd0, in_ch.frame_code[32:1]};
    end

    // A stale partial PIN is dropped before the item itself is looked at.
    cnt_eff = digit_count;
    if ((digit_count != '0) && (idle_ticks > idle_timeout_ticks)) begin
      cnt_eff = '0;
    end

    digit_count_next = digit_count;
    idle_ticks_next  = idle_ticks;
    want_push        = 1'b0;
    q_data.op        = OP_CARD;
    q_data.code      = card;
    q_data.bits      = in_ch.frame_bits;
    q_data.digit     = key;
    q_data.cnt       = CMD_CNT_W'(cnt_eff);

    if (in_ch.locked) begin
      digit_count_next = cnt_eff;
      if (in_ch.action) begin
        if (idle_ticks != '1) begin
          idle_ticks_next = idle_ticks + TIMEOUT_W'(1);
        end
      end else if (is_key) begin
        if (key_ok) begin
          if (key < FIRST_TERM_KEY) begin
            if (cnt_eff != CNT_W'(PinCapacity)) begin
              want_push        = 1'b1;
              q_data.op        = OP_APPEND;
              digit_count_next = cnt_eff + CNT_W'(1);
              idle_ticks_next  = '0;
            end
          end else begin
            want_push        = (cnt_eff != '0);
            q_data.op        = OP_DRAIN;
            digit_count_next = '0;
          end
        end
      end else begin
        want_push = 1'b1;
      end
    end
  end

  assign q_push = in_acc && want_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= IDLE_TIMEOUT_RST;
      digit_count        <= '0;
      idle_ticks         <= '0;
    end else begin
      if (cfg_wr_en) begin
        idle_timeout_ticks <= cfg_wr_data;
      end
      if (in_acc) begin
        digit_count <= digit_count_next;
        idle_ticks  <= idle_ticks_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(PinCapacity))
    else $error("digit count above capacity");

  a_unlocked_no_effect: assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_ch.locked |=> $stable(digit_count) && $stable(idle_ticks))
    else $error("unlocked item changed PIN state");

  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> in_acc && !q_full)
    else $error("command pushed without an accepted request");
`endif

endmodule

`default_nettype wire

[src/wkpc_queue.sv]
`default_nettype none

module wkpc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wkpc_pkg::cmd_t push_data,
  output      logic           full,
  input  wire logic           pop,
  output      logic           not_empty,
  output      wkpc_pkg::cmd_t head
);
  import wkpc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [LVL_W-1:0] level;
  logic             do_push;
  logic             do_pop;

  assign full      = (level == LVL_W'(QUEUE_DEPTH));
  assign not_empty = (level != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level <= level + LVL_W'(1);
      end else if (do_pop && !do_push) begin
        level <= level - LVL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[src/wkpc_back.sv]
`default_nettype none

module wkpc_back #(
  parameter int PinCapacity = wkpc_pkg::PIN_CAPACITY_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_not_empty,
  input  wire wkpc_pkg::cmd_t q_head,
  output      logic           q_pop,
  wkpc_out_if.source          out_ch
);
  import wkpc_pkg::*;

  localparam int CNT_W = $clog2(PinCapacity + 1);
  localparam int IDX_W = (PinCapacity > 1) ? $clog2(PinCapacity) : 1;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } back_state_t;

  back_state_t state, state_next;

  logic [DIGIT_W-1:0] digit_mem [PinCapacity];
  logic [DIGIT_W-1:0] rd_data;
  logic [IDX_W-1:0]   rd_addr;
  logic               mem_we;

  logic [CNT_W-1:0]  drain_cnt;
  logic [CNT_W-1:0]  drain_idx;
  logic [CNT_W-1:0]  drain_idx_inc;
  logic [BITS_W-1:0] drain_bits;
  logic              last_hit;

  logic              out_free;
  logic              pop_card;
  logic              pop_drain;
  logic              emit_digit;

  logic              out_valid;
  logic              out_kind;
  logic [CODE_W-1:0] out_code;
  logic [DIGIT_W-1:0] out_digit;
  logic [BITS_W-1:0] out_bits;
  logic              out_last;

  assign out_free      = !out_valid || out_ch.ready;
  assign drain_idx_inc = drain_idx + CNT_W'(1);
  assign last_hit      = (drain_idx_inc == drain_cnt);
  assign emit_digit    = (state == ST_DRAIN) && out_free;

  always_comb begin
    q_pop      = 1'b0;
    pop_card   = 1'b0;
    pop_drain  = 1'b0;
    mem_we     = 1'b0;
    state_next = state;
    rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (q_not_empty) begin
          case (q_head.op)
            OP_APPEND: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            OP_CARD: begin
              q_pop    = out_free;
              pop_card = out_free;
            end
            OP_DRAIN: begin
              q_pop      = 1'b1;
              pop_drain  = 1'b1;
              state_next = ST_DRAIN;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // The read for the next digit goes out in the cycle the current one
        // is handed to the output register, so one digit leaves per cycle while the output register is free.
        rd_addr = emit_digit ? drain_idx_inc[IDX_W-1:0] : drain_idx[IDX_W-1:0];
        if (emit_digit && last_hit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[q_head.cnt[IDX_W-1:0]] <= q_head.digit;
    end
    rd_data <= digit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop_drain) begin
      drain_cnt  <= q_head.cnt[CNT_W-1:0];
      drain_bits <= q_head.bits;
      drain_idx  <= '0;
    end else if (emit_digit) begin
      drain_idx <= drain_idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_card) begin
      out_kind  <= 1'b0;
      out_code  <= q_head.code;
      out_digit <= '0;
      out_bits  <= q_head.bits;
      out_last  <= 1'b1;
    end else if (emit_digit) begin
      out_kind  <= 1'b1;
      out_code  <= '0;
      out_digit <= rd_data;
      out_bits  <= drain_bits;
      out_last  <= last_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (pop_card || emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_kind;
  assign out_ch.card_code   = out_code;
  assign out_ch.pin_digit   = out_digit;
  assign out_ch.source_bits = out_bits;
  assign out_ch.last        = out_last;

`ifndef SYNTHESIS
  a_drain_index: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> drain_idx < drain_cnt)
    else $error("drain index past stored digit count");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    emit_digit && last_hit |=> state == ST_IDLE && out_valid && out_last)
    else $error("drain did not end on the last digit");

  a_card_loaded: assert property (@(posedge clk) disable iff (rst)
    pop_card |=> out_valid && !out_kind && out_last)
    else $error("card command not placed in output register");

  a_no_pop_in_drain: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> !q_pop)
    else $error("queue popped during a drain");
`endif

endmodule

`default_nettype wire

[src/wiegand_keypad_pin_collector.sv]
`default_nettype none

// Path: a card request goes through the command queue into the output register; a PIN
//   terminator's stored digits leave one a cycle while the output register is free.
// Throughput: one request a cycle is accepted while the two-entry command queue has
//   room; a terminator holds the digit drain unit until its last digit is handed out.
// Reset: synchronous, active high; clears the digit count, idle count, queue and
//   output valid, and loads the idle timeout with 10000. The digit store is not cleared.
module wiegand_keypad_pin_collector #(
  parameter int PinCapacity = wkpc_pkg::PIN_CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [wkpc_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  wkpc_in_if.sink                             in_ch,
  wkpc_out_if.source                          out_ch
);
  import wkpc_pkg::*;

  logic q_push;
  cmd_t q_push_data;
  logic q_full;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_head;

  wkpc_front #(
    .PinCapacity(PinCapacity)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  wkpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  wkpc_back #(
    .PinCapacity(PinCapacity)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

[tb/wkpc_tb_pkg.sv]
package wkpc_tb_pkg;

  typedef enum logic {
    ACT_FRAME = 1'b0,
    ACT_TICK  = 1'b1
  } action_t;

  typedef enum logic {
    KIND_CARD  = 1'b0,
    KIND_DIGIT = 1'b1
  } result_kind_t;

  typedef struct packed {
    action_t                           action;
    logic [wkpc_pkg::CODE_W-1:0]       code;
    logic [wkpc_pkg::BITS_W-1:0]       bits;
    logic                              locked;
  } frame_req_t;

  typedef struct packed {
    result_kind_t                      kind;
    logic [wkpc_pkg::CODE_W-1:0]       card;
    logic [wkpc_pkg::DIGIT_W-1:0]      digit;
    logic [wkpc_pkg::BITS_W-1:0]       bits;
    logic                              last;
  } pin_result_t;

endpackage

[tb/wkpc_output_checker.sv]
module wkpc_output_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [wkpc_pkg::TIMEOUT_W-1:0] cfg_wr_data,
  wkpc_in_if                             in_mon,
  wkpc_out_if                            out_mon,
  output int                             error_count,
  output int                             expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  import wkpc_pkg::*;
  import wkpc_tb_pkg::*;

  localparam int MAX_REPORTS = 30;

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [DIGIT_W-1:0]   pin_digits [PIN_CAPACITY_DEF];
  int                   pin_len;
  logic [TIMEOUT_W-1:0] idle_count;
  pin_result_t          owed_results [$];

  function automatic void owe(input result_kind_t kind, input logic [CODE_W-1:0] card,
                              input logic [DIGIT_W-1:0] digit,
                              input logic [BITS_W-1:0] bits, input logic last);
    pin_result_t r;
    r.kind  = kind;
    r.card  = card;
    r.digit = digit;
    r.bits  = bits;
    r.last  = last;
    owed_results.push_back(r);
  endfunction

  // Applies one accepted request to the PIN state and queues what it must produce.
  function automatic void collect_step(input frame_req_t req);
    logic [DIGIT_W-1:0] key;
    logic [CODE_W-1:0]  card;
    if (!req.locked) return;
    if (pin_len > 0 && idle_count > timeout_ticks) pin_len = 0;
    if (req.action == ACT_TICK) begin
      if (idle_count != '1) idle_count++;
      return;
    end
    if (req.bits == KEY4_BITS || req.bits == KEY8_BITS) begin
      key = req.code[3:0];
      // A wide key carries the complement of the key in its upper nibble.
      if (req.bits == KEY8_BITS && req.code[7:4] != ~key) return;
      if (key < FIRST_TERM_KEY) begin
        if (pin_len < PIN_CAPACITY_DEF) begin
          pin_digits[pin_len] = key;
          pin_len++;
          idle_count = '0;
        end
        return;
      end
      for (int i = 0; i < pin_len; i++) begin
        owe(KIND_DIGIT, '0, pin_digits[i], req.bits, i == pin_len - 1);
      end
      pin_len = 0;
      return;
    end
    card = req.code;
    if (req.bits == CARD26_BITS) begin
      card = {40'b0, req.code[24:1]};
    end else if (req.bits == CARD34_BITS) begin
      card = {32'b0, req.code[32:1]};
    end
    owe(KIND_CARD, card, '0, req.bits, 1'b1);
  endfunction

  function automatic void check_field(input string name, input logic [CODE_W-1:0] want,
                                      input logic [CODE_W-1:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    pin_result_t want;
    frame_req_t  req;
    if (rst) begin
      timeout_ticks = IDLE_TIMEOUT_RST;
      pin_len       = 0;
      idle_count    = '0;
      error_count   = 0;
      owed_results.delete();
    end else begin
      if (cfg_wr_en) timeout_ticks = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) begin
        if (owed_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result with none expected, actual kind %0d card %h digit %0d",
                     $time, out_mon.kind, out_mon.card_code, out_mon.pin_digit);
          end
        end else begin
          want = owed_results.pop_front();
          check_field("kind", want.kind, out_mon.kind);
          check_field("card_code", want.card, out_mon.card_code);
          check_field("pin_digit", want.digit, out_mon.pin_digit);
          check_field("source_bits", want.bits, out_mon.source_bits);
          check_field("last", want.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        req.action = action_t'(in_mon.action);
        req.code   = in_mon.frame_code;
        req.bits   = in_mon.frame_bits;
        req.locked = in_mon.locked;
        collect_step(req);
      end
    end
    expected_left = owed_results.size();
  end

endmodule

[tb/tb_wiegand_keypad_pin_collector.sv]
module tb_wiegand_keypad_pin_collector;
  timeunit 1ns;
  timeprecision 1ps;

  import wkpc_pkg::*;
  import wkpc_tb_pkg::*;

  localparam int RANDOM_ITEMS = 460;
  localparam int PER_PHASE    = RANDOM_ITEMS / 10;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_WAIT   = 24;
  localparam int HOLD_CYCLES  = 400;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [TIMEOUT_W-1:0] cfg_wr_data;

  wkpc_in_if  in_ch ();
  wkpc_out_if out_ch ();

  int                   error_count;
  int                   expected_left;
  bit                   steady;
  bit                   hold_req;
  int                   burst_left;
  int                   counted;
  logic [TIMEOUT_W-1:0] timeout_now;

  wiegand_keypad_pin_collector u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  wkpc_output_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .error_count   (error_count),
    .expected_left (expected_left)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic frame_req_t frame_of(input action_t action, input logic [CODE_W-1:0] code,
                                          input logic [BITS_W-1:0] bits, input logic locked);
    frame_req_t r;
    r.action = action;
    r.code   = code;
    r.bits   = bits;
    r.locked = locked;
    return r;
  endfunction

  function automatic frame_req_t key_frame(input logic [DIGIT_W-1:0] key, input bit wide);
    frame_req_t r;
    r = frame_of(ACT_FRAME, {$urandom, $urandom}, KEY4_BITS, 1'b1);
    r.code[3:0] = key;
    if (wide) begin
      r.bits      = KEY8_BITS;
      r.code[7:4] = ~key;
    end
    return r;
  endfunction

  function automatic frame_req_t tick_frame();
    return frame_of(ACT_TICK, {$urandom, $urandom}, BITS_W'($urandom_range(0, 127)), 1'b1);
  endfunction

  // Sends one request, opening a gap of random length between bursts.
  task automatic offer(input frame_req_t r);
    int gap;
    if (!steady && burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.action     = r.action;
    in_ch.frame_code = r.code;
    in_ch.frame_bits = r.bits;
    in_ch.locked     = r.locked;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (r.locked && !(r.action == ACT_FRAME && r.bits == KEY8_BITS &&
                      r.code[7:4] != ~r.code[3:0])) begin
      counted++;
    end
  endtask

  task automatic wait_all_done();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
    wait_all_done();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    timeout_now = value;
  endtask

  // One digit, a run of ticks, then a terminator: the digit survives only if the
  // tick count stays at or below the timeout.
  task automatic timeout_probe(input int ticks);
    steady = 1'b1;
    offer(key_frame(DIGIT_W'($urandom_range(0, 9)), 1'($urandom_range(0, 1))));
    repeat (ticks) offer(tick_frame());
    offer(key_frame(DIGIT_W'($urandom_range(10, 15)), 1'($urandom_range(0, 1))));
    steady = 1'b0;
  endtask

  task automatic directed_items();
    logic [CODE_W-1:0] ones;
    ones = '1;
    offer(frame_of(ACT_FRAME, ones, CARD26_BITS, 1'b1));
    offer(frame_of(ACT_FRAME, ones, CARD34_BITS, 1'b1));
    offer(frame_of(ACT_FRAME, '0, BITS_W'(0), 1'b1));
    offer(frame_of(ACT_FRAME, ones, BITS_W'(64), 1'b1));
    offer(frame_of(ACT_FRAME, ones, BITS_W'(127), 1'b1));
    offer(key_frame(DIGIT_W'(0), 1'b0));
    offer(key_frame(DIGIT_W'(9), 1'b1));
    // Wide key whose upper nibble is not the complement: dropped.
    offer(frame_of(ACT_FRAME, 64'h55, KEY8_BITS, 1'b1));
    offer(frame_of(ACT_FRAME, 64'h3, KEY4_BITS, 1'b0));
    offer(frame_of(ACT_TICK, ones, BITS_W'(0), 1'b0));
    // Fill the PIN past capacity; the extra digits must be dropped.
    repeat (15) offer(key_frame(DIGIT_W'($urandom_range(0, 9)), 1'($urandom_range(0, 1))));
    offer(key_frame(FIRST_TERM_KEY, 1'b0));
    // A terminator with nothing stored produces nothing.
    offer(frame_of(ACT_FRAME, 64'h0F, KEY8_BITS, 1'b1));
  endtask

  task automatic pin_sequence();
    int digits;
    digits = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
    repeat (digits) begin
      if (timeout_now <= 50 && $urandom_range(0, 7) == 0) begin
        repeat (timeout_now + 1) offer(tick_frame());
      end else if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 2)) offer(tick_frame());
      end
      if ($urandom_range(0, 15) == 0) begin
        offer(frame_of(action_t'($urandom_range(0, 1)), {$urandom, $urandom},
                       BITS_W'($urandom_range(0, 127)), 1'b0));
      end
      offer(key_frame(DIGIT_W'($urandom_range(0, 9)), 1'($urandom_range(0, 1))));
    end
    offer(key_frame(DIGIT_W'($urandom_range(10, 15)), 1'($urandom_range(0, 1))));
  endtask

  task automatic random_phase(input int target);
    int   start;
    int   pick;
    logic [3:0] lo;
    logic [3:0] hi;
    frame_req_t r;
    start = counted;
    while (counted - start < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pin_sequence();
      end else if (pick < 75) begin
        pick = $urandom_range(0, 99);
        r = frame_of(ACT_FRAME, {$urandom, $urandom}, BITS_W'($urandom_range(0, 127)), 1'b1);
        if (pick < 35) begin
          r.bits = CARD26_BITS;
        end else if (pick < 60) begin
          r.bits = CARD34_BITS;
        end
        offer(r);
      end else if (pick < 85) begin
        repeat ((timeout_now <= 50) ? $urandom_range(1, timeout_now + 2) : $urandom_range(1, 3))
          offer(tick_frame());
      end else if (pick < 92) begin
        lo = 4'($urandom_range(0, 15));
        hi = ~lo ^ 4'($urandom_range(1, 15));
        r = frame_of(ACT_FRAME, {$urandom, $urandom}, KEY8_BITS, 1'b1);
        r.code[7:0] = {hi, lo};
        offer(r);
      end else begin
        offer(frame_of(action_t'($urandom_range(0, 1)), {$urandom, $urandom},
                       BITS_W'($urandom_range(0, 127)), 1'b0));
      end
    end
  endtask

  task automatic run_setting(input logic [TIMEOUT_W-1:0] value);
    set_timeout(value);
    if (value <= 50) begin
      timeout_probe(int'(value));
      timeout_probe(int'(value) + 1);
    end
    random_phase(PER_PHASE);
  endtask

  initial begin : stimulus
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.action     = 1'b0;
    in_ch.frame_code = '0;
    in_ch.frame_bits = '0;
    in_ch.locked     = 1'b0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    burst_left       = 0;
    counted          = 0;
    timeout_now      = IDLE_TIMEOUT_RST;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    directed_items();

    // Stall the result side for a long stretch while cards keep coming, so the
    // command queue fills and the input side has to back off.
    hold_req = 1'b1;
    steady   = 1'b1;
    repeat (12) begin
      offer(frame_of(ACT_FRAME, {$urandom, $urandom},
                     ($urandom_range(0, 1) == 1) ? CARD26_BITS : CARD34_BITS, 1'b1));
    end
    steady = 1'b0;
    wait_all_done();

    random_phase(PER_PHASE);
    run_setting('0);
    run_setting(TIMEOUT_W'(1));
    run_setting(TIMEOUT_W'(3));
    run_setting(TIMEOUT_W'(1000000));
    run_setting(TIMEOUT_W'($urandom_range(2, 30)));

    wait_all_done();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && expected_left == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : receiver
    int run_left;
    int stall_left;
    out_ch.ready = 1'b0;
    run_left     = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (run_left > 0) begin
        out_ch.ready = 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        run_left   = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        stall_left = $urandom_range(1, 5);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule
